@@ rtl/core/simu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simu_pkg
// Shared types and constants for the SOS interface Metropolis update core.
// ----------------------------------------------------------------------------
package simu_pkg;

  localparam int SITE_W   = 12;
  localparam int RAND_W   = 16;
  localparam int HEIGHT_W = 16;
  localparam int HSUM_W   = 28;
  localparam int SSUM_W   = 42;
  localparam int STOT_W   = 43;
  localparam int THR_W    = 17;
  localparam int LIM_W    = 15;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int SITES_DEFAULT = 4096;
  localparam int RECIP_SHIFT   = 24;

  localparam logic [THR_W-1:0] ACCEPT_THRESHOLD_RESET = 17'd19433;
  localparam logic [LIM_W-1:0] HEIGHT_LIMIT_RESET     = 15'd4000;

  // register index, taken from paddr[2]
  localparam logic REG_ACCEPT_THRESHOLD = 1'b0;
  localparam logic REG_HEIGHT_LIMIT     = 1'b1;

  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic              direction;
    logic [RAND_W-1:0] random_value;
  } simu_proposal_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [HEIGHT_W-1:0] new_height;
    logic signed [HSUM_W-1:0]   height_sum;
    logic [SSUM_W-1:0]          square_sum;
  } simu_result_t;

endpackage

@@ rtl/core/sos_interface_metropolis_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_interface_metropolis_update_core
// Proposals pass registers s1, s2, s3, then the result beat; one proposal per
// cycle unless result_ready stalls or clearing runs. The two height RAMs are
// read at s2 and written at s3, with a one-entry write bypass covering the
// overlap. Reset: sync, active high; then a clearing pass zeroes the height
// RAMs, proposal_ready stays low meanwhile. Config resets to defaults.
// ----------------------------------------------------------------------------
module sos_interface_metropolis_update_core #(
  parameter int SITES = simu_pkg::SITES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [simu_pkg::PADDR_W-1:0]  paddr,
  input  logic [simu_pkg::PDATA_W-1:0]  pwdata,
  output logic [simu_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          proposal_valid,
  output logic                          proposal_ready,
  input  simu_pkg::simu_proposal_t      proposal,
  output logic                          result_valid,
  input  logic                          result_ready,
  output simu_pkg::simu_result_t        result
);
  import simu_pkg::*;

  localparam int AW     = $clog2(SITES);
  localparam int RECIP  = (1 << RECIP_SHIFT) / SITES;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = SITE_W + RW;
  localparam int QMAX   = ((1 << SITE_W) - 1) / SITES;
  localparam int QW     = (QMAX >= 1) ? $clog2(QMAX + 1) : 1;
  localparam int CW     = ((AW > SITE_W) ? AW : SITE_W) + 1;

  // config registers
  logic [THR_W-1:0] accept_threshold;
  logic [LIM_W-1:0] height_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_threshold <= ACCEPT_THRESHOLD_RESET;
      height_limit     <= HEIGHT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ACCEPT_THRESHOLD: accept_threshold <= pwdata[THR_W-1:0];
        REG_HEIGHT_LIMIT:     height_limit     <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ACCEPT_THRESHOLD: prdata = PDATA_W'(accept_threshold);
      REG_HEIGHT_LIMIT:     prdata = PDATA_W'(height_limit);
      default:              prdata = '0;
    endcase
  end

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(SITES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline control
  logic s1_valid, s2_valid, s3_valid;
  logic out_en, s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv, s3_adv, in_acc;

  assign out_en  = !result_valid || result_ready;
  assign s3_adv  = s3_valid && out_en;
  assign s3_free = !s3_valid || out_en;
  assign s2_adv  = s2_valid && s3_free;
  assign s2_free = !s2_valid || s3_free;
  assign s1_adv  = s1_valid && s2_free;
  assign s1_free = !s1_valid || s2_free;
  assign proposal_ready = !clearing && s1_free;
  assign in_acc  = proposal_valid && proposal_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= in_acc;
      if (s2_free) s2_valid <= s1_adv;
      if (s3_free) s3_valid <= s2_adv;
      if (out_en)  result_valid <= s3_valid;
    end
  end

  // s0: reciprocal multiply for the ring reduction
  logic [PW-1:0] prod;
  assign prod = PW'(proposal.site) * PW'(RECIP);

  logic [SITE_W-1:0] s1_site;
  logic [QW-1:0]     s1_q;
  logic              s1_dir;
  logic [RAND_W-1:0] s1_rnd;

  // s1: remainder with one correction step
  logic [CW-1:0] qs, rem0, rem1;
  logic [AW-1:0] x1;
  assign qs   = CW'(s1_q * SITES);
  assign rem0 = CW'(s1_site) - qs;
  assign rem1 = (rem0 >= CW'(SITES)) ? rem0 - CW'(SITES) : rem0;
  assign x1   = AW'(rem1);

  logic [AW-1:0]     s2_x;
  logic              s2_dir;
  logic [RAND_W-1:0] s2_rnd;

  // s2: neighbor addresses, RAM read
  logic [AW-1:0] xp2, xm2;
  assign xp2 = (s2_x == AW'(SITES - 1)) ? '0 : s2_x + 1'b1;
  assign xm2 = (s2_x == '0) ? AW'(SITES - 1) : s2_x - 1'b1;

  logic [AW-1:0]     s3_x, s3_xp, s3_xm;
  logic              s3_dir;
  logic [RAND_W-1:0] s3_rnd;

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_site <= proposal.site;
      s1_q    <= QW'(prod >> RECIP_SHIFT);
      s1_dir  <= proposal.direction;
      s1_rnd  <= proposal.random_value;
    end
    if (s2_free) begin
      s2_x   <= x1;
      s2_dir <= s1_dir;
      s2_rnd <= s1_rnd;
    end
    if (s3_free) begin
      s3_x   <= s2_x;
      s3_xp  <= xp2;
      s3_xm  <= xm2;
      s3_dir <= s2_dir;
      s3_rnd <= s2_rnd;
    end
  end

  // height RAMs: center copy and neighbor copy, identical contents
  logic [HEIGHT_W-1:0] mem_c [SITES];
  logic [HEIGHT_W-1:0] mem_n [SITES];
  logic signed [HEIGHT_W-1:0] rd_c, rd_p, rd_m;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [HEIGHT_W-1:0] mem_wdata;
  logic                s3_wr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_c[mem_waddr] <= mem_wdata;
      mem_n[mem_waddr] <= mem_wdata;
    end
    if (s2_adv) begin
      rd_c <= mem_c[s2_x];
      rd_p <= mem_n[xp2];
      rd_m <= mem_n[xm2];
    end
  end

  // bypass: last write made
  logic                fwd_valid;
  logic [AW-1:0]       fwd_addr;
  logic [HEIGHT_W-1:0] fwd_data;

  // s3: decide, update
  logic signed [HEIGHT_W-1:0] h, hp, hm;
  logic signed [HEIGHT_W:0]   h_ext, h2, lim, neg_lim;
  logic                       in_range, uphill, rnd_ok, ok;
  logic [HSUM_W-1:0]          height_total, height_next;
  logic [STOT_W-1:0]          square_total, square_next, h2x, dsq;

  assign h  = (fwd_valid && fwd_addr == s3_x)  ? fwd_data : rd_c;
  assign hp = (fwd_valid && fwd_addr == s3_xp) ? fwd_data : rd_p;
  assign hm = (fwd_valid && fwd_addr == s3_xm) ? fwd_data : rd_m;

  assign h_ext   = {h[HEIGHT_W-1], h};
  assign h2      = s3_dir ? h_ext + 17'sd1 : h_ext - 17'sd1;
  assign lim     = {2'b00, height_limit};
  assign neg_lim = -lim;
  assign in_range = (h2 > neg_lim) && (h2 < lim);
  // energy rises by 2 only when the site moves away from both neighbors
  assign uphill  = s3_dir ? (h >= hm && h >= hp) : (h <= hm && h <= hp);
  assign rnd_ok  = {1'b0, s3_rnd} < accept_threshold;
  assign ok      = in_range && (!uphill || rnd_ok);

  assign height_next = s3_dir ? height_total + 1'b1 : height_total - 1'b1;
  assign h2x         = {{(STOT_W - HEIGHT_W - 1){h[HEIGHT_W-1]}}, h, 1'b0};
  assign dsq         = s3_dir ? h2x + 1'b1 : STOT_W'(1) - h2x;
  assign square_next = square_total + dsq;

  assign s3_wr     = s3_adv && ok;
  assign mem_we    = clearing || s3_wr;
  assign mem_waddr = clearing ? clr_addr : s3_x;
  assign mem_wdata = clearing ? '0 : h2[HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid    <= 1'b0;
      height_total <= '0;
      square_total <= '0;
    end else if (s3_wr) begin
      fwd_valid    <= 1'b1;
      height_total <= height_next;
      square_total <= square_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_wr) begin
      fwd_addr <= s3_x;
      fwd_data <= h2[HEIGHT_W-1:0];
    end
    if (s3_adv) begin
      result.accepted   <= ok;
      result.new_height <= ok ? h2[HEIGHT_W-1:0] : h;
      result.height_sum <= ok ? height_next : height_total;
      result.square_sum <= ok ? square_next[SSUM_W-1:0] : square_total[SSUM_W-1:0];
    end
  end

endmodule
